// ===== hdl/s256_pkg.sv =====
// Package with the shared types, constants and round functions of the SHA-256 hash unit.
`default_nettype none
package s256_pkg;

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [5:0] LENGTH_OFFSET = 6'd56;
  localparam logic [5:0] LAST_SLOT     = 6'd63;
  localparam logic [2:0] LAST_WORD     = 3'd7;
  localparam logic       CMD_ABSORB    = 1'b0;
  localparam logic       CMD_FINISH    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       load;
    logic       round;
    logic [5:0] rnd;
    logic       update;
    logic       init;
  } ctl_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/s256_sched.sv =====
// Block buffer and message schedule as one 16-word shift line.
`default_nettype none
module s256_sched (
  input  wire logic          clk,
  input  wire s256_pkg::ctl_t ctl,
  output logic [31:0]        w_cur
);
  import s256_pkg::*;

  logic [511:0] line_r;
  logic [511:0] line_nxt;
  logic [31:0]  w_new;

  assign w_cur = line_r[511:480];
  assign w_new = line_r[511:480] + small_sig0(line_r[479:448]) +
                 line_r[223:192] + small_sig1(line_r[63:32]);

  always_comb begin
    line_nxt = line_r;
    if (ctl.push) begin
      line_nxt = {line_r[503:0], ctl.push_byte};
    end else if (ctl.round) begin
      line_nxt = {line_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    line_r <= line_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/s256_core.sv =====
// Round datapath with the working variables and the chaining words.
`default_nettype none
module s256_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire s256_pkg::ctl_t ctl,
  input  wire logic [31:0]    w_cur,
  input  wire logic [2:0]     word_sel,
  output logic [31:0]         chain_word
);
  import s256_pkg::*;

  logic [31:0] v_r     [8];
  logic [31:0] chain_r [8];
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) +
              ROUND_K[ctl.rnd] + w_cur;
  assign t2 = big_sig0(v_r[0]) +
              ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign chain_word = chain_r[word_sel];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= chain_r[i];
      end
    end else if (ctl.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= INIT_H[i];
      end
    end else if (ctl.update) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_r[i] + v_r[i];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sha256_stream_hash_unit.sv =====
// Top level of the SHA-256 stream hash unit with its sequencer.
// An absorb transaction pushes one byte; the byte that fills a block starts a compression
// (64 rounds of the shared round unit and one chaining update).
// A finish transaction pushes one padding byte per cycle, runs one or two compressions
// and then presents the eight digest words, one per cycle while the sink is ready.
// Reset loads the initial hash values and clears the fill and bit counts.
`default_nettype none
module sha256_stream_hash_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // digest_word, word_index, zero fill
  output logic             out_tlast   // last_word
);
  import s256_pkg::*;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [63:0] len_r, len_nxt;
  logic        fin_r, fin_nxt;
  logic        mark_r, mark_nxt;
  logic        lenph_r, lenph_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;

  ctl_t        ctl;
  logic [31:0] w_cur;
  logic [31:0] chain_word;
  logic        in_acc;
  logic        out_acc;
  logic        len_now;
  logic [5:0]  len_sh;
  logic [7:0]  pad_byte;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign len_now = mark_r && (lenph_r || fill_r == LENGTH_OFFSET);
  assign len_sh  = {3'd7 - fill_r[2:0], 3'b000};
  assign pad_byte = !mark_r ? PAD_MARK : (len_now ? 8'(len_r >> len_sh) : 8'h00);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == CMD_FINISH) begin
            state_nxt = ST_PAD;
          end else if (fill_r == LAST_SLOT) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == LAST_SLOT) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == LAST_SLOT) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (lenph_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc && oidx_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.rnd    = rnd_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    fill_nxt   = fill_r;
    bitlen_nxt = bitlen_r;
    len_nxt    = len_r;
    fin_nxt    = fin_r;
    mark_nxt   = mark_r;
    lenph_nxt  = lenph_r;
    rnd_nxt    = rnd_r;
    oidx_nxt   = oidx_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          if (in_tuser == CMD_FINISH) begin
            len_nxt = bitlen_r;
            fin_nxt = 1'b1;
          end else begin
            ctl.push      = 1'b1;
            ctl.push_byte = in_tdata;
            ctl.load      = (fill_r == LAST_SLOT);
            fill_nxt      = fill_r + 6'd1;
            bitlen_nxt    = bitlen_r + 64'd8;
            rnd_nxt       = '0;
          end
        end
      end
      ST_PAD: begin
        ctl.push      = 1'b1;
        ctl.push_byte = pad_byte;
        ctl.load      = (fill_r == LAST_SLOT);
        fill_nxt      = fill_r + 6'd1;
        mark_nxt      = 1'b1;
        lenph_nxt     = lenph_r || len_now;
        rnd_nxt       = '0;
      end
      ST_ROUND: begin
        ctl.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
      end
      ST_UPDATE: begin
        ctl.update = 1'b1;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_acc) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == LAST_WORD) begin
            ctl.init   = 1'b1;
            bitlen_nxt = '0;
            fin_nxt    = 1'b0;
            mark_nxt   = 1'b0;
            lenph_nxt  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tdata = {5'b00000, oidx_r, chain_word};
  assign out_tlast = (oidx_r == LAST_WORD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      bitlen_r <= '0;
      fin_r    <= 1'b0;
      mark_r   <= 1'b0;
      lenph_r  <= 1'b0;
      rnd_r    <= '0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      bitlen_r <= bitlen_nxt;
      fin_r    <= fin_nxt;
      mark_r   <= mark_nxt;
      lenph_r  <= lenph_nxt;
      rnd_r    <= rnd_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  s256_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .w_cur (w_cur)
  );

  s256_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .w_cur      (w_cur),
    .word_sel   (oidx_r),
    .chain_word (chain_word)
  );

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while a digest word is pending");

  a_digest_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && fill_r == 6'd0 &&
                                                 bitlen_r == 64'd0))
    else $error("state not returned to initial after the last digest word");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == LAST_SLOT) |=> (state_r == ST_UPDATE && rnd_r == 6'd0))
    else $error("compression did not end after the last round");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the SHA-256 stream hash unit with a built-in digest predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import s256_pkg::CMD_ABSORB;
  import s256_pkg::CMD_FINISH;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD    = 400;

  localparam bit [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic       cmd;
    logic [7:0] data;
    bit         drain_first;
  } stream_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  typedef enum {RX_STREAM, RX_HALF, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  stream_item_t byte_stream[$];
  digest_word_t digest_words_due[$];

  bit [31:0] chain_h [8];
  bit [7:0]  msg_block [64];
  bit [5:0]  msg_fill;
  bit [63:0] msg_bits;

  int       mismatch_count = 0;
  int       items_accepted = 0;
  int       directed_items = 0;
  int       cycle_count = 0;
  bit       in_accepted = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  bit       long_hold_done = 1'b0;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_STREAM;

  sha256_stream_hash_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic bit [31:0] rotr(bit [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    chain_h = SHA_H0;
    msg_fill = 6'd0;
    msg_bits = 64'd0;
  endfunction

  function automatic void hash_compress();
    bit [31:0] w [64];
    bit [31:0] v [8];
    bit [31:0] s0;
    bit [31:0] s1;
    bit [31:0] t1;
    bit [31:0] t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = chain_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      chain_h[i] = chain_h[i] + v[i];
    end
  endfunction

  function automatic void hash_push(bit [7:0] b);
    msg_block[msg_fill] = b;
    msg_fill = msg_fill + 6'd1;
    if (msg_fill == 6'd0) begin
      hash_compress();
    end
  endfunction

  // The length field encodes the bit count as it stood before padding.
  function automatic void hash_finish();
    bit [63:0]    len;
    digest_word_t dw;
    len = msg_bits;
    hash_push(8'h80);
    while (msg_fill != 6'd56) begin
      hash_push(8'h00);
    end
    for (int i = 0; i < 8; i++) begin
      hash_push(len[63 - 8*i -: 8]);
    end
    for (int i = 0; i < 8; i++) begin
      dw.word = chain_h[i];
      dw.index = i[2:0];
      dw.last = (i == 7);
      digest_words_due.push_back(dw);
    end
    hash_restart();
  endfunction

  function automatic void add_item(logic cmd, logic [7:0] data, bit drain_first);
    stream_item_t it;
    it.cmd = cmd;
    it.data = data;
    it.drain_first = drain_first;
    byte_stream.push_back(it);
  endfunction

  function automatic void add_message(int len, bit drain_first);
    for (int k = 0; k < len; k++) begin
      add_item(CMD_ABSORB, 8'($urandom_range(0, 255)), drain_first && k == 0);
    end
    add_item(CMD_FINISH, 8'($urandom_range(0, 255)), drain_first && len == 0);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_tvalid && !in_accepted)) begin
        in_accepted = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (byte_stream.size() == 0 ||
                     (byte_stream[0].drain_first && digest_words_due.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser <= byte_stream[0].cmd;
          in_tdata <= byte_stream[0].data;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && out_tvalid && items_accepted > directed_items) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STREAM: out_tready <= 1'b1;
          RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
          default:   out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (digest_words_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected digest transaction: word %h index %0d last %0b",
                     out_tdata[31:0], out_tdata[34:32], out_tlast);
          end
        end else begin
          exp_w = digest_words_due.pop_front();
          if (out_tdata[31:0] !== exp_w.word || out_tdata[34:32] !== exp_w.index ||
              out_tlast !== exp_w.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Digest mismatch: expected word %h index %0d last %0b, got %h %0d %0b",
                       exp_w.word, exp_w.index, exp_w.last,
                       out_tdata[31:0], out_tdata[34:32], out_tlast);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        in_accepted = 1'b1;
        items_accepted++;
        if (in_tuser == CMD_FINISH) begin
          hash_finish();
        end else begin
          hash_push(in_tdata);
          msg_bits = msg_bits + 64'd8;
        end
        void'(byte_stream.pop_front());
      end
    end
  end

  initial begin
    int finishes;
    hash_restart();

    add_item(CMD_FINISH, 8'h00, 1'b0);
    add_item(CMD_ABSORB, 8'h00, 1'b0);
    add_item(CMD_FINISH, 8'hff, 1'b0);
    add_item(CMD_ABSORB, 8'hff, 1'b0);
    add_item(CMD_FINISH, 8'h00, 1'b0);
    add_item(CMD_ABSORB, 8'h61, 1'b0);
    add_item(CMD_ABSORB, 8'h62, 1'b0);
    add_item(CMD_ABSORB, 8'h63, 1'b0);
    add_item(CMD_FINISH, 8'h5a, 1'b0);
    add_item(CMD_FINISH, 8'ha5, 1'b0);
    add_item(CMD_ABSORB, 8'h80, 1'b0);
    add_item(CMD_ABSORB, 8'h7f, 1'b0);
    add_item(CMD_ABSORB, 8'h01, 1'b0);
    add_item(CMD_ABSORB, 8'hfe, 1'b0);
    add_item(CMD_ABSORB, 8'h55, 1'b0);
    add_item(CMD_ABSORB, 8'haa, 1'b0);
    add_item(CMD_FINISH, 8'hff, 1'b0);
    directed_items = byte_stream.size();

    // Message lengths around one block put the padding on either side of the boundary.
    add_message($urandom_range(54, 66), 1'b1);
    finishes = 1;
    while (byte_stream.size() < 110 || finishes < 6) begin
      add_message(($urandom_range(0, 7) == 0) ? $urandom_range(11, 70) : $urandom_range(0, 10),
                  1'b0);
      finishes++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_stream.size() != 0 || digest_words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
